### src/three_point_curvature_assert.svh
// Assertion macros for the three point curvature block.
// Included by the modules that check themselves; expects clk and rst in scope.
`ifndef THREE_POINT_CURVATURE_ASSERT_SVH
`define THREE_POINT_CURVATURE_ASSERT_SVH

// implication checked at every clock edge outside reset
`define TPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen outside reset
`define TPC_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### src/tpc_pkg.sv
// Shared constants for the three point curvature block.
// No dependencies.
package tpc_pkg;
  localparam int SQRT_FRAC_BITS = 16;   // extra fraction bits on each length
  localparam int DIFF_W         = 33;   // coordinate difference
  localparam int SQ_IN_W        = 66;   // dx^2 + dy^2
  localparam int ROOT_W         = (SQ_IN_W + 2 * SQRT_FRAC_BITS) / 2;
  localparam int ABSX_W         = 66;   // cross product magnitude
  localparam int Q_W            = 33;   // quotient bits kept below the saturation check
  localparam int MUL_CHUNK      = 24;   // partial product slice width
endpackage

### src/tpc_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// No package dependencies.
module tpc_sqrt #(
  parameter int N = 49
) (
  input  logic           clk,
  input  logic           en,
  input  logic [2*N-1:0] radicand,
  output logic [N-1:0]   root
);

  logic [N+1:0]   rem_q  [N];
  logic [N-1:0]   root_q [N];
  logic [2*N-1:0] rad_q  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [N+1:0]   rem_p;
    logic [N-1:0]   root_p;
    logic [2*N-1:0] rad_p;
    logic [N+2:0]   cat;
    logic [N+2:0]   trial;
    logic [N+2:0]   diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = radicand;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign rad_p  = rad_q[k-1];
    end

    assign cat   = {rem_p[N:0], rad_p[2*N-1:2*N-2]};
    assign trial = {1'b0, root_p, 2'b01};
    assign diff  = cat - trial;
    assign ge    = !diff[N+2];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? diff[N+1:0] : cat[N+1:0];
        root_q[k] <= {root_p[N-2:0], ge};
        rad_q[k]  <= {rad_p[2*N-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[N-1];

endmodule

### src/tpc_mul.sv
// Two stage wide unsigned multiplier: sliced partial products, then their sum.
// Depends on tpc_pkg for the slice width.
module tpc_mul #(
  parameter int WA = 49,
  parameter int WB = 49
) (
  input  logic            clk,
  input  logic            en,
  input  logic [WA-1:0]   a,
  input  logic [WB-1:0]   b,
  output logic [WA+WB-1:0] p
);

  localparam int C  = tpc_pkg::MUL_CHUNK;
  localparam int NA = (WA + C - 1) / C;
  localparam int NB = (WB + C - 1) / C;
  localparam int PW = (NA + NB) * C;

  logic [NA*C-1:0] a_pad;
  logic [NB*C-1:0] b_pad;
  logic [2*C-1:0]  pp [NA*NB];
  logic [PW-1:0]   acc;

  assign a_pad = (NA*C)'(a);
  assign b_pad = (NB*C)'(b);

  for (genvar i = 0; i < NA; i++) begin : g_a
    for (genvar j = 0; j < NB; j++) begin : g_b
      always_ff @(posedge clk) begin
        if (en) pp[i*NB+j] <= a_pad[i*C +: C] * b_pad[j*C +: C];
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (PW'(pp[i*NB+j]) << ((i + j) * C));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) p <= acc[WA+WB-1:0];
  end

endmodule

### src/three_point_curvature.sv
// Signed curvature of the circle through three points: 2*cross(BC,AC) / (|AC|*|BC|*|AB|),
// in the coordinate fixed-point format. A fully pipelined datapath takes one item per
// cycle; its depth is the 49-stage square roots, the wide multipliers and the restoring
// divider (load stage plus 33 quotient-bit stages). An output stall freezes the whole
// pipeline. Degenerate triples give 0 with the degenerate flag; out-of-range results clip.
`include "three_point_curvature_assert.svh"

module three_point_curvature #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] point_a_x,
  input  logic signed [31:0] point_a_y,
  input  logic signed [31:0] point_b_x,
  input  logic signed [31:0] point_b_y,
  input  logic signed [31:0] point_c_x,
  input  logic signed [31:0] point_c_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] curvature,
  output logic               degenerate,
  output logic               saturated
);

  localparam int DW  = tpc_pkg::DIFF_W;
  localparam int RW  = tpc_pkg::ROOT_W;
  localparam int XW  = tpc_pkg::ABSX_W;
  localparam int QW  = tpc_pkg::Q_W;
  localparam int SH  = 1 + 2 * COORD_FRAC_BITS + 3 * tpc_pkg::SQRT_FRAC_BITS;
  localparam int NW  = XW + SH;
  localparam int DNW = 3 * RW;
  localparam int MW  = DNW + QW;
  localparam int CW  = (NW > MW + 1) ? NW : MW + 1;
  localparam int SBA = RW + 4;
  localparam int SBB = QW + 1;
  localparam int VD  = SBA + SBB;

  typedef struct packed {
    logic [XW-1:0] absx;
    logic          neg;
    logic          zero;
  } side_a_t;

  typedef struct packed {
    logic neg;
    logic zero;
    logic sat_hi;
  } side_b_t;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: differences
  logic signed [DW-1:0] abx, aby, bcx, bcy, acx, acy;
  logic v1, v2, v3;

  always_ff @(posedge clk) begin
    if (en) begin
      abx <= DW'(point_b_x) - DW'(point_a_x);
      aby <= DW'(point_b_y) - DW'(point_a_y);
      bcx <= DW'(point_c_x) - DW'(point_b_x);
      bcy <= DW'(point_c_y) - DW'(point_b_y);
      acx <= DW'(point_c_x) - DW'(point_a_x);
      acy <= DW'(point_c_y) - DW'(point_a_y);
    end
  end

  // stage 2: squares and cross terms
  logic signed [2*DW-1:0] sq_abx, sq_aby, sq_bcx, sq_bcy, sq_acx, sq_acy, p1, p2;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_abx <= abx * abx;
      sq_aby <= aby * aby;
      sq_bcx <= bcx * bcx;
      sq_bcy <= bcy * bcy;
      sq_acx <= acx * acx;
      sq_acy <= acy * acy;
      p1     <= acy * bcx;
      p2     <= acx * bcy;
    end
  end

  // stage 3: squared lengths, cross product magnitude and sign
  logic [tpc_pkg::SQ_IN_W-1:0] s_ab, s_bc, s_ac, s_ab_n, s_bc_n, s_ac_n;
  logic signed [2*DW:0]        xc;
  side_a_t                     sa3, sa3_n;

  always_comb begin
    s_ab_n     = tpc_pkg::SQ_IN_W'(unsigned'(sq_abx)) + tpc_pkg::SQ_IN_W'(unsigned'(sq_aby));
    s_bc_n     = tpc_pkg::SQ_IN_W'(unsigned'(sq_bcx)) + tpc_pkg::SQ_IN_W'(unsigned'(sq_bcy));
    s_ac_n     = tpc_pkg::SQ_IN_W'(unsigned'(sq_acx)) + tpc_pkg::SQ_IN_W'(unsigned'(sq_acy));
    xc         = (2*DW+1)'(p1) - (2*DW+1)'(p2);
    sa3_n.neg  = xc[2*DW];
    sa3_n.absx = xc[2*DW] ? XW'(-xc) : XW'(xc);
    sa3_n.zero = (s_ab_n == '0) || (s_bc_n == '0) || (s_ac_n == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_ab <= s_ab_n;
      s_bc <= s_bc_n;
      s_ac <= s_ac_n;
      sa3  <= sa3_n;
    end
  end

  // segment lengths
  logic [RW-1:0] r_ab, r_bc, r_ac;

  tpc_sqrt #(.N(RW)) u_sqrt_ab (
    .clk(clk), .en(en), .radicand({s_ab, (2*tpc_pkg::SQRT_FRAC_BITS)'(0)}), .root(r_ab));
  tpc_sqrt #(.N(RW)) u_sqrt_bc (
    .clk(clk), .en(en), .radicand({s_bc, (2*tpc_pkg::SQRT_FRAC_BITS)'(0)}), .root(r_bc));
  tpc_sqrt #(.N(RW)) u_sqrt_ac (
    .clk(clk), .en(en), .radicand({s_ac, (2*tpc_pkg::SQRT_FRAC_BITS)'(0)}), .root(r_ac));

  // denominator
  logic [2*RW-1:0] den2;
  logic [DNW-1:0]  den;
  logic [RW-1:0]   rab_d [2];

  always_ff @(posedge clk) begin
    if (en) begin
      rab_d[0] <= r_ab;
      rab_d[1] <= rab_d[0];
    end
  end

  tpc_mul #(.WA(RW), .WB(RW)) u_mul_lo (
    .clk(clk), .en(en), .a(r_ac), .b(r_bc), .p(den2));
  tpc_mul #(.WA(2*RW), .WB(RW)) u_mul_hi (
    .clk(clk), .en(en), .a(den2), .b(rab_d[1]), .p(den));

  // sideband and valid delay lines
  side_a_t sa_d [SBA];
  side_b_t sb_d [SBB];
  logic    vpipe [VD];

  always_ff @(posedge clk) begin
    if (en) begin
      sa_d[0] <= sa3;
      for (int i = 1; i < SBA; i++) sa_d[i] <= sa_d[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      for (int i = 0; i < VD; i++) vpipe[i] <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      vpipe[0] <= v3;
      for (int i = 1; i < VD; i++) vpipe[i] <= vpipe[i-1];
    end
  end

  // divider: first stage loads the numerator and checks for a quotient of 2^33 or more
  logic [MW-1:0]  rem_q [SBB];
  logic [DNW-1:0] den_q [SBB];
  logic [QW-1:0]  q_q   [SBB];
  logic [CW-1:0]  num_w;
  side_a_t        sa_last;

  assign sa_last = sa_d[SBA-1];
  assign num_w   = CW'(sa_last.absx) << SH;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0]     <= num_w[MW-1:0];
      den_q[0]     <= den;
      q_q[0]       <= '0;
      sb_d[0].neg    <= sa_last.neg;
      sb_d[0].zero   <= sa_last.zero;
      sb_d[0].sat_hi <= num_w >= (CW'(den) << QW);
    end
  end

  for (genvar j = 1; j < SBB; j++) begin : g_div
    localparam int K = QW - j;
    logic [MW-1:0] trial;
    logic          ge;

    assign trial = MW'(den_q[j-1]) << K;
    assign ge    = rem_q[j-1] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j] <= ge ? rem_q[j-1] - trial : rem_q[j-1];
        den_q[j] <= den_q[j-1];
        q_q[j]   <= q_q[j-1] | (QW'(ge) << K);
        sb_d[j]  <= sb_d[j-1];
      end
    end
  end

  // result formatting
  logic [QW-1:0] qf;
  side_b_t       sbf;
  logic          over, sat;
  logic [31:0]   res;

  assign qf  = q_q[SBB-1];
  assign sbf = sb_d[SBB-1];

  always_comb begin
    over = sbf.neg ? (qf > QW'(33'h0_8000_0000)) : (qf > QW'(33'h0_7FFF_FFFF));
    sat  = sbf.sat_hi || over;
    if (sat) res = sbf.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else     res = sbf.neg ? 32'(-qf) : qf[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vpipe[VD-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      curvature  <= sbf.zero ? 32'sd0 : signed'(res);
      degenerate <= sbf.zero;
      saturated  <= sbf.zero ? 1'b0 : sat;
    end
  end

  `TPC_ASSERT(a_degen_zero, (out_valid && degenerate) |-> (curvature == 0 && !saturated), "degenerate item with nonzero result")
  `TPC_ASSERT(a_sat_clip, (out_valid && saturated) |-> (curvature == 32'sh7FFF_FFFF || curvature == 32'sh8000_0000), "saturated item not clipped")
  `TPC_ASSERT(a_stall_link, in_stall == (out_valid && out_stall), "input stall out of step with output")
  `TPC_NEVER(a_flags_both, out_valid && degenerate && saturated, "both flags set")

endmodule

### verif/three_point_curvature_tb.sv
// Self-checking bench for three_point_curvature: directed triples, then random ones.
// Expected curvature is written in the row, else comes from a wide-integer predictor in this file.
// Depends on tpc_pkg and the three_point_curvature RTL.
module three_point_curvature_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_FRAC_BITS = 16;
  localparam int NUM_RANDOM      = 450;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 120;

  typedef struct {
    logic signed [31:0] ax, ay, bx, by, cx, cy;
  } triple_t;

  typedef struct {
    logic signed [31:0] curv;
    logic               degen;
    logic               sat;
  } curv_t;

  typedef struct {
    triple_t pts;
    bit      typed;  // expected value written in the row
    curv_t   want;
  } row_t;

  typedef enum int {IDLE_SEND_LIGHT, IDLE_RECV_LIGHT, IDLE_NONE} idle_mode_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] point_a_x = '0, point_a_y = '0;
  logic signed [31:0] point_b_x = '0, point_b_y = '0;
  logic signed [31:0] point_c_x = '0, point_c_y = '0;
  logic               out_valid;
  logic               out_stall = 1'b1;
  logic signed [31:0] curvature;
  logic               degenerate;
  logic               saturated;

  curv_t      pending_curv[$];
  int         mismatches = 0;
  int         cycles = 0;
  idle_mode_t idle_mode = IDLE_SEND_LIGHT;

  three_point_curvature #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) dut (
    .clk, .rst, .in_valid, .in_stall,
    .point_a_x, .point_a_y, .point_b_x, .point_b_y, .point_c_x, .point_c_y,
    .out_valid, .out_stall, .curvature, .degenerate, .saturated
  );

  always #10 clk = ~clk;

  // floor(sqrt(dx^2 + dy^2) * 2^SQRT_FRAC_BITS); zero flags a zero-length segment
  function automatic logic [48:0] seg_length(input logic signed [32:0] dx,
                                             input logic signed [32:0] dy,
                                             inout bit zero);
    logic [32:0] mx, my;
    logic [65:0] sum;
    logic [97:0] target, sq;
    logic [48:0] root, cand;
    mx = dx[32] ? 33'(-dx) : 33'(dx);
    my = dy[32] ? 33'(-dy) : 33'(dy);
    sum = 66'(mx) * 66'(mx) + 66'(my) * 66'(my);
    if (sum == '0) begin
      zero = 1'b1;
      return '0;
    end
    target = {sum, 32'b0};
    root = '0;
    for (int b = 48; b >= 0; b--) begin
      cand = root | (49'(1) << b);
      sq = 98'(cand) * 98'(cand);
      if (sq <= target) root = cand;
    end
    return root;
  endfunction

  function automatic curv_t predict_curvature(input triple_t t);
    logic signed [32:0] abx, aby, bcx, bcy, acx, acy;
    logic signed [66:0] cross_prod;
    logic [66:0]        cross_mag;
    logic [48:0]        r_ac, r_bc, r_ab;
    logic [199:0]       num, den, quo, lim;
    bit                 zero;
    logic               neg;
    curv_t              r;
    abx = 33'(t.bx) - 33'(t.ax);
    aby = 33'(t.by) - 33'(t.ay);
    bcx = 33'(t.cx) - 33'(t.bx);
    bcy = 33'(t.cy) - 33'(t.by);
    acx = 33'(t.cx) - 33'(t.ax);
    acy = 33'(t.cy) - 33'(t.ay);
    zero = 1'b0;
    r_ac = seg_length(acx, acy, zero);
    r_bc = seg_length(bcx, bcy, zero);
    r_ab = seg_length(abx, aby, zero);
    if (zero) begin
      r.curv = '0;
      r.degen = 1'b1;
      r.sat = 1'b0;
      return r;
    end
    cross_prod = 67'(acy) * 67'(bcx) - 67'(acx) * 67'(bcy);
    neg = cross_prod[66];
    cross_mag = neg ? 67'(-cross_prod) : 67'(cross_prod);
    num = 200'(cross_mag) << (1 + 2 * COORD_FRAC_BITS + 3 * tpc_pkg::SQRT_FRAC_BITS);
    den = 200'(r_ac) * 200'(r_bc) * 200'(r_ab);
    quo = num / den;
    lim = neg ? 200'h8000_0000 : 200'h7FFF_FFFF;
    r.degen = 1'b0;
    r.sat = quo > lim;
    if (r.sat) r.curv = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else r.curv = neg ? -quo[31:0] : quo[31:0];
    return r;
  endfunction

  function automatic triple_t mk(input logic [31:0] ax, ay, bx, by, cx, cy);
    triple_t t;
    t.ax = ax; t.ay = ay; t.bx = bx; t.by = by; t.cx = cx; t.cy = cy;
    return t;
  endfunction

  function automatic curv_t res(input logic [31:0] c, input logic d, input logic s);
    curv_t r;
    r.curv = c; r.degen = d; r.sat = s;
    return r;
  endfunction

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SEND_LIGHT: return $urandom_range(0, 99) < 20;
      IDLE_RECV_LIGHT: return $urandom_range(0, 99) < 88;
      default:         return 1'b0;
    endcase
  endfunction

  task automatic send_triple(input triple_t t, input curv_t want);
    while (sender_idles()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    point_a_x <= t.ax; point_a_y <= t.ay;
    point_b_x <= t.bx; point_b_y <= t.by;
    point_c_x <= t.cx; point_c_y <= t.cy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_curv = {pending_curv, want};
    @(negedge clk);
  endtask

  // small triangle of random scale and base, or fully random, coincident or collinear points
  function automatic triple_t random_triple();
    triple_t t;
    logic [31:0] base_x, base_y;
    int span;
    base_x = $urandom();
    base_y = $urandom();
    span = 1 << $urandom_range(0, 24);
    case ($urandom_range(0, 9)) inside
      [0:4]: begin
        t = mk(base_x, base_y,
               base_x + 32'($signed($urandom_range(0, 2 * span)) - span),
               base_y + 32'($signed($urandom_range(0, 2 * span)) - span),
               base_x + 32'($signed($urandom_range(0, 2 * span)) - span),
               base_y + 32'($signed($urandom_range(0, 2 * span)) - span));
      end
      [5:6]: t = mk($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      7: begin
        t = mk(base_x, base_y, $urandom(), $urandom(), $urandom(), $urandom());
        case ($urandom_range(0, 2))
          0: begin t.bx = t.ax; t.by = t.ay; end
          1: begin t.cx = t.bx; t.cy = t.by; end
          default: begin t.cx = t.ax; t.cy = t.ay; end
        endcase
      end
      8: begin
        t = mk(base_x, base_y, base_x + span, base_y + 3 * span,
               base_x + 2 * span, base_y + 6 * span);
      end
      default: begin
        t = mk(base_x, base_y, base_x + $urandom_range(0, 3), base_y + $urandom_range(0, 3),
               base_x + $urandom_range(0, 3), base_y + $urandom_range(0, 3));
      end
    endcase
    return t;
  endfunction

  initial begin
    row_t    rows[$];
    row_t    rw;
    triple_t t;

    // degenerate, collinear and clipping cases are easy to write down
    rw.typed = 1; rw.pts = mk(0, 0, 0, 0, 0, 0);   rw.want = res(0, 1, 0); rows = {rows, rw};
    rw.pts = mk(5, 7, 5, 7, 100, 3);               rw.want = res(0, 1, 0); rows = {rows, rw};
    rw.pts = mk(5, 7, 9, 1, 9, 1);                 rw.want = res(0, 1, 0); rows = {rows, rw};
    rw.pts = mk(5, 7, 9, 1, 5, 7);                 rw.want = res(0, 1, 0); rows = {rows, rw};
    rw.pts = mk(0, 0, 1, 1, 2, 2);                 rw.want = res(0, 0, 0); rows = {rows, rw};
    rw.pts = mk(0, 0, 1, 0, 0, 1);      rw.want = res(32'h8000_0000, 0, 1); rows = {rows, rw};
    rw.pts = mk(0, 0, 0, 1, 1, 0);      rw.want = res(32'h7FFF_FFFF, 0, 1); rows = {rows, rw};
    rw.pts = mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF); rw.want = res(0, 1, 0); rows = {rows, rw};
    // collinear along the full-scale diagonal
    rw.pts = mk(32'h8000_0000, 32'h8000_0000, 0, 0,
                32'h7FFF_FFFF, 32'h7FFF_FFFF); rw.want = res(0, 0, 0); rows = {rows, rw};
    rw.typed = 0;
    rw.want = res(0, 0, 0);
    rw.pts = mk(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF);
    rows = {rows, rw};
    rw.pts = mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF);
    rows = {rows, rw};
    rw.pts = mk(32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF, 32'h8000_0000, 0);
    rows = {rows, rw};
    // unit circle through (1,0),(0,1),(-1,0) in Q16.16
    rw.pts = mk(32'h0001_0000, 0, 0, 32'h0001_0000, 32'hFFFF_0000, 0);
    rows = {rows, rw};
    rw.pts = mk(32'hFFFF_0000, 0, 0, 32'h0001_0000, 32'h0001_0000, 0);
    rows = {rows, rw};
    rw.pts = mk(0, 0, 32'h0100_0000, 1, 32'h0200_0000, 0);
    rows = {rows, rw};
    rw.pts = mk(0, 0, 32'h0000_0010, 0, 0, 32'h0000_0020);
    rows = {rows, rw};
    // all three points equal
    rw.typed = 1; rw.pts = mk(10, 20, 10, 20, 10, 20); rw.want = res(0, 1, 0); rows = {rows, rw};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) begin
      send_triple(rows[i].pts,
                  rows[i].typed ? rows[i].want : predict_curvature(rows[i].pts));
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 3) idle_mode = IDLE_RECV_LIGHT;
      if (n == 2 * NUM_RANDOM / 3) idle_mode = IDLE_NONE;
      t = random_triple();
      send_triple(t, predict_curvature(t));
    end
    in_valid <= 1'b0;

    while (pending_curv.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // receiver stall; one long hold-off when the no-idle phase starts so the pipe backs up
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(negedge clk);
      if (idle_mode == IDLE_NONE && !hold_done) begin
        hold_done = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (idle_mode)
          IDLE_SEND_LIGHT: out_stall <= $urandom_range(0, 99) < 88;
          IDLE_RECV_LIGHT: out_stall <= $urandom_range(0, 99) < 20;
          default:         out_stall <= 1'b0;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    curv_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_curv.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: curvature %h degenerate %b saturated %b",
                   curvature, degenerate, saturated);
      end else begin
        want = pending_curv.pop_front();
        if (curvature !== want.curv || degenerate !== want.degen || saturated !== want.sat)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: curvature %h/%h degenerate %b/%b saturated %b/%b (exp/got)",
                     want.curv, curvature, want.degen, degenerate, want.sat, saturated);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items outstanding", cycles, pending_curv.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end
endmodule
